/* rtl/core/e2q_pkg.sv */
package e2q_pkg;

	localparam int ANGLE_BITS = 16;
	localparam int TRIG_ITERATIONS = 16;
	localparam int FIELD_W = 16;
	localparam int QW = 16;
	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
	localparam logic signed [33:0] CORDIC_K_Q30 = 34'sh26DD3B6A;
	localparam logic signed [15:0] Q14_ONE = 16'sd16384;

	typedef struct packed {
		logic signed [FIELD_W-1:0] roll_angle;
		logic signed [FIELD_W-1:0] pitch_angle;
		logic signed [FIELD_W-1:0] yaw_angle;
	} e2q_in_t;

	typedef struct packed {
		logic signed [QW-1:0] quat_w;
		logic signed [QW-1:0] quat_x;
		logic signed [QW-1:0] quat_y;
		logic signed [QW-1:0] quat_z;
	} e2q_out_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [63:0] z;
	} e2q_rot_t;

	typedef struct packed {
		e2q_rot_t r;
		e2q_rot_t p;
		e2q_rot_t y;
	} e2q_cell_t;

	function automatic logic signed [63:0] atan_q60(input int i);
		logic [63:0] acc;
		logic [63:0] term;
		int odd;
		int e;
		acc = 64'd0;
		if (i == 0) begin
			return 64'((PI_Q60 + 64'd2) >> 2);
		end
		for (int k = 0; k < 32; k++) begin
			odd = 2 * k + 1;
			e = i * odd;
			if (e <= 62) begin
				term = (64'd1 << (62 - e)) / 64'(odd);
				if (k % 2 == 1) acc = acc - term;
				else acc = acc + term;
			end
		end
		return 64'((acc + 64'd2) >> 2);
	endfunction

	function automatic logic signed [63:0] half_rad(input logic [FIELD_W-1:0] raw);
		logic [ANGLE_BITS-1:0] v;
		logic neg;
		logic [ANGLE_BITS:0] mag;
		logic [127:0] prod;
		logic [63:0] r;
		v = ANGLE_BITS'({{(ANGLE_BITS > FIELD_W ? ANGLE_BITS-FIELD_W : 0){1'b0}}, raw});
		neg = v[ANGLE_BITS-1];
		mag = neg ? ((ANGLE_BITS+1)'(1) << ANGLE_BITS) - {1'b0, v} : {1'b0, v};
		prod = 128'(mag) * 128'(PI_Q60);
		r = 64'(prod >> ANGLE_BITS);
		return neg ? -$signed(r) : $signed(r);
	endfunction

endpackage

/* rtl/core/e2q_cell.sv */
module e2q_cell (
	input logic clk,
	input logic arst_n,
	input logic step_in,
	input e2q_pkg::e2q_cell_t cell_in,
	output logic step_out,
	output e2q_pkg::e2q_cell_t cell_out,
	input logic signed [63:0] atan_val,
	input logic [4:0] shift
);
	import e2q_pkg::*;

	function automatic e2q_rot_t rot(input e2q_rot_t a, input logic signed [63:0] t,
			input logic [4:0] s);
		e2q_rot_t o;
		o = a;
		if (a.z >= 0) begin
			o.x = a.x - (a.y >>> s);
			o.y = a.y + (a.x >>> s);
			o.z = a.z - t;
		end else begin
			o.x = a.x + (a.y >>> s);
			o.y = a.y - (a.x >>> s);
			o.z = a.z + t;
		end
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_out <= 1'b0;
		end else begin
			step_out <= step_in;
		end
	end

	always_ff @(posedge clk) begin
		cell_out.r <= rot(cell_in.r, atan_val, shift);
		cell_out.p <= rot(cell_in.p, atan_val, shift);
		cell_out.y <= rot(cell_in.y, atan_val, shift);
	end

endmodule

/* rtl/core/e2q_combine.sv */
module e2q_combine (
	input logic clk,
	input logic arst_n,
	input logic step_in,
	input e2q_pkg::e2q_cell_t cell_in,
	output logic strobe,
	output e2q_pkg::e2q_out_t result
);
	import e2q_pkg::*;

	function automatic logic signed [33:0] mul30(input logic signed [33:0] a,
			input logic signed [33:0] b);
		logic signed [67:0] p;
		p = 68'(a) * 68'(b) + 68'sd536870912;
		return 34'(p >>> 30);
	endfunction

	function automatic logic signed [15:0] to_q14(input logic signed [35:0] v);
		logic signed [35:0] r;
		r = (v + 36'sd32768) >>> 16;
		if (r > 36'sd16384) r = 36'sd16384;
		if (r < -36'sd16384) r = -36'sd16384;
		return 16'(r);
	endfunction

	logic [2:0] vld_q;
	logic signed [33:0] cy_s1, sy_s1;
	logic signed [33:0] cc_s1, cs_s1, sc_s1, ss_s1;
	logic signed [33:0] ccc_s2, sss_s2, scc_s2, css_s2, csc_s2, scs_s2, ccs_s2, ssc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[1:0], step_in};
		end
	end

	always_ff @(posedge clk) begin
		cy_s1 <= cell_in.y.x;
		sy_s1 <= cell_in.y.y;
		cc_s1 <= mul30(cell_in.r.x, cell_in.p.x);
		cs_s1 <= mul30(cell_in.r.x, cell_in.p.y);
		sc_s1 <= mul30(cell_in.r.y, cell_in.p.x);
		ss_s1 <= mul30(cell_in.r.y, cell_in.p.y);
		ccc_s2 <= mul30(cc_s1, cy_s1);
		sss_s2 <= mul30(ss_s1, sy_s1);
		scc_s2 <= mul30(sc_s1, cy_s1);
		css_s2 <= mul30(cs_s1, sy_s1);
		csc_s2 <= mul30(cs_s1, cy_s1);
		scs_s2 <= mul30(sc_s1, sy_s1);
		ccs_s2 <= mul30(cc_s1, sy_s1);
		ssc_s2 <= mul30(ss_s1, cy_s1);
		result.quat_w <= to_q14(36'(ccc_s2) + 36'(sss_s2));
		result.quat_x <= to_q14(36'(scc_s2) - 36'(css_s2));
		result.quat_y <= to_q14(36'(csc_s2) + 36'(scs_s2));
		result.quat_z <= to_q14(36'(ccs_s2) - 36'(ssc_s2));
	end

	assign strobe = vld_q[2];

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (result.quat_w <= Q14_ONE && result.quat_w >= -Q14_ONE))
		else $error("quat_w beyond clamp");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		step_in |-> ##3 strobe)
		else $error("result strobe lost");
	a_orig: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(strobe) |-> $past(step_in, 3))
		else $error("spurious result strobe");

endmodule

/* rtl/core/euler_to_quaternion.sv */
// Converts Z-Y-X Euler angles (roll, pitch, yaw as binary angles) to a unit
// quaternion in Q2.14.
// A transaction is accepted on a rising edge with start high and busy low.
// Busy is tied low: a new angle triple may be accepted on every cycle.
// The result appears on the result port for one cycle with done high.
// The input passes an angle scaling register, then the chain of CORDIC
// cells, one rotation step per cell, followed by two multiplier stages and
// a rounding stage.
// Throughput is one transaction per clock cycle.
// Reset clears all valid flags so no result is reported until new input
// has passed through the chain. The receiver cannot stall, so results are
// never held back.
module euler_to_quaternion (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input e2q_pkg::e2q_in_t angles,
	output logic done,
	output e2q_pkg::e2q_out_t result
);
	import e2q_pkg::*;

	localparam int N = TRIG_ITERATIONS;

	logic step_q [N+1];
	e2q_cell_t cell_q [N+1];
	logic conv_vld_q;
	e2q_cell_t conv_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_vld_q <= 1'b0;
		end else begin
			conv_vld_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		conv_q.r <= '{x: CORDIC_K_Q30, y: '0, z: half_rad(angles.roll_angle)};
		conv_q.p <= '{x: CORDIC_K_Q30, y: '0, z: half_rad(angles.pitch_angle)};
		conv_q.y <= '{x: CORDIC_K_Q30, y: '0, z: half_rad(angles.yaw_angle)};
	end

	assign step_q[0] = conv_vld_q;
	assign cell_q[0] = conv_q;

	for (genvar i = 0; i < N; i++) begin : g_cell
		e2q_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.step_in(step_q[i]),
			.cell_in(cell_q[i]),
			.step_out(step_q[i+1]),
			.cell_out(cell_q[i+1]),
			.atan_val(atan_q60(i)),
			.shift(5'(i))
		);
	end

	e2q_combine u_combine (
		.clk(clk),
		.arst_n(arst_n),
		.step_in(step_q[N]),
		.cell_in(cell_q[N]),
		.strobe(done),
		.result(result)
	);

endmodule

/* bench/tb_euler_to_quaternion.sv */
`timescale 1ns / 100ps

module tb_euler_to_quaternion;
	import e2q_pkg::*;

	localparam int LATENCY = TRIG_ITERATIONS + 4;

	class quat_scoreboard;
		e2q_out_t pending[$];
		int mismatches;
		int checked;

		function new();
			mismatches = 0;
			checked = 0;
		endfunction

		static function longint atan_step(int i);
			longint unsigned acc;
			longint unsigned term;
			int odd;
			int e;
			acc = 0;
			if (i == 0) begin
				return longint'((64'h3243F6A8885A308D + 64'd2) >> 2);
			end
			for (int k = 0; k < 40; k++) begin
				odd = 2 * k + 1;
				e = i * odd;
				if (e > 62) break;
				term = (64'd1 << (62 - e)) / longint'(odd);
				if (k[0]) acc = acc - term;
				else acc = acc + term;
			end
			return longint'((acc + 64'd2) >> 2);
		endfunction

		static function void half_trig(logic [15:0] raw, output longint c, output longint s);
			longint unsigned v;
			longint unsigned mag;
			logic [127:0] prod;
			longint z;
			longint x;
			longint y;
			longint dx;
			longint dy;
			longint a;
			bit neg;
			v = raw & ((64'd1 << ANGLE_BITS) - 1);
			neg = v[ANGLE_BITS-1];
			mag = neg ? ((64'd1 << ANGLE_BITS) - v) : v;
			prod = 128'(mag) * 128'(64'h3243F6A8885A308D);
			z = longint'(64'(prod >> ANGLE_BITS));
			if (neg) z = -z;
			x = 64'h26DD3B6A;
			y = 0;
			for (int i = 0; i < TRIG_ITERATIONS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				a = atan_step(i);
				if (z >= 0) begin
					x = x - dx; y = y + dy; z = z - a;
				end else begin
					x = x + dx; y = y - dy; z = z + a;
				end
			end
			c = x;
			s = y;
		endfunction

		static function longint mul_q30(longint a, longint b);
			return (a * b + (64'sd1 <<< 29)) >>> 30;
		endfunction

		static function longint triple(longint a, longint b, longint c);
			return mul_q30(mul_q30(a, b), c);
		endfunction

		static function logic signed [15:0] round_q14(longint v);
			longint r;
			r = (v + 64'sd32768) >>> 16;
			if (r > 16384) r = 16384;
			if (r < -16384) r = -16384;
			return 16'(r);
		endfunction

		function void note_angles(e2q_in_t a);
			longint cr, sr, cp, sp, cy, sy;
			e2q_out_t q;
			half_trig(a.roll_angle, cr, sr);
			half_trig(a.pitch_angle, cp, sp);
			half_trig(a.yaw_angle, cy, sy);
			q.quat_w = round_q14(triple(cr, cp, cy) + triple(sr, sp, sy));
			q.quat_x = round_q14(triple(sr, cp, cy) - triple(cr, sp, sy));
			q.quat_y = round_q14(triple(cr, sp, cy) + triple(sr, cp, sy));
			q.quat_z = round_q14(triple(cr, cp, sy) - triple(sr, sp, cy));
			pending = {pending, q};
		endfunction

		function void check_quat(e2q_out_t got);
			e2q_out_t exp_q;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result w=%0d x=%0d y=%0d z=%0d", got.quat_w,
						got.quat_x, got.quat_y, got.quat_z);
				return;
			end
			exp_q = pending.pop_front();
			checked++;
			if (got !== exp_q) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch: exp w=%0d x=%0d y=%0d z=%0d, got w=%0d x=%0d y=%0d z=%0d",
						exp_q.quat_w, exp_q.quat_x, exp_q.quat_y, exp_q.quat_z,
						got.quat_w, got.quat_x, got.quat_y, got.quat_z);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	e2q_in_t angles;
	logic done;
	e2q_out_t result;

	quat_scoreboard sb;
	int sent;

	euler_to_quaternion dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.angles(angles),
		.done(done),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n && done) sb.check_quat(result);
	end

	// The transaction is noted at the edge where it is taken.
	task automatic send_angles(logic [15:0] r, logic [15:0] p, logic [15:0] y, bit keep);
		start <= 1'b1;
		angles <= '{roll_angle: r, pitch_angle: p, yaw_angle: y};
		do @(posedge clk); while (busy);
		sb.note_angles('{roll_angle: r, pitch_angle: p, yaw_angle: y});
		sent++;
		if (!keep) start <= 1'b0;
	endtask

	task automatic idle_burst();
		start <= 1'b0;
		repeat ($urandom_range(1, 12)) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_angle();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'(16'h4000 + $urandom_range(0, 64) - 32);
			4: return 16'(16'hC000 + $urandom_range(0, 64) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [15:0] edge_vals[8];
		int idx;
		sb = new();
		sent = 0;
		arst_n = 1'b0;
		start = 1'b0;
		angles = '0;
		edge_vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h4000,
			16'hC000, 16'h5555};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 8; i++) send_angles(edge_vals[i], 16'h0000, 16'h0000, 1'b1);
		for (int i = 0; i < 8; i++) send_angles(16'h0000, edge_vals[i], 16'h0000, 1'b1);
		for (int i = 0; i < 8; i++) send_angles(edge_vals[i], edge_vals[7 - i], edge_vals[i], 1'b1);
		start <= 1'b0;

		// Drain the pipeline completely before the random phase.
		while (sb.pending.size() != 0) @(posedge clk);

		for (int n = 0; n < 1200; n++) begin
			if (n < 1000 && $urandom_range(0, 5) == 0) idle_burst();
			if ($urandom_range(0, 3) == 0)
				send_angles(pick_angle(), pick_angle(), pick_angle(), 1'b1);
			else
				send_angles(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
		end
		start <= 1'b0;

		idx = 0;
		while (sb.pending.size() != 0 && idx < 100 * LATENCY) begin
			@(posedge clk);
			idx++;
		end
		repeat (LATENCY + 4) @(posedge clk);

		$display("Sent %0d angle triples, %0d quaternions checked, %0d mismatches.",
			sent, sb.checked, sb.mismatches);
		$display("Covered angle extremes, half-turn wrap and random triples with idle gaps.");
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("Timed out.");
		$display("== FAIL ==");
		$finish;
	end

endmodule
